// ===== sv/rrbr_pkg.sv =====
// Shared types and constants for the receive ring buffer reader.
// Used by the front end, the back end and the top level; depends on nothing.
`default_nettype none

package rrbr_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;

  // Request modes as they arrive on the input stream.
  localparam logic [1:0] MODE_RX    = 2'd0;
  localparam logic [1:0] MODE_READ1 = 2'd1;
  localparam logic [1:0] MODE_DELIM = 2'd2;
  localparam logic [1:0] MODE_COUNT = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_OVERRUN   = 2'd2;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

  // Wrap count saturates here.
  localparam logic [1:0] WRAP_SAT = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TAKE  = 2'd1,
    CMD_SCAN  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [BYTE_W-1:0] data;  // received byte or delimiter
    logic [CNT_W-1:0]  len;   // clamped byte limit
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              byte_valid;
    logic [CNT_W-1:0]  byte_count;
    logic [1:0]        status;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/rrbr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module rrbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rrbr_front.sv =====
// Front end: decodes incoming requests into commands and queues them.
// Depends on rrbr_pkg for the command type and mode codes.
`default_nettype none

module rrbr_front
  import rrbr_pkg::*;
#(
  parameter int MAX_READ = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire logic [BYTE_W-1:0] delimiter_i,
  input  wire logic [CNT_W-1:0]  max_length_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output cmd_t                   cmd_o
);

  localparam logic [CNT_W-1:0] MaxLen = CNT_W'(MAX_READ);

  cmd_t       dec_cmd;
  logic [CNT_W-1:0] len_clamped;
  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign len_clamped = (max_length_i > MaxLen) ? MaxLen : max_length_i;

  always_comb begin
    dec_cmd.kind = CMD_WRITE;
    dec_cmd.data = '0;
    dec_cmd.len  = '0;
    unique case (mode_i)
      MODE_RX: begin
        dec_cmd.kind = CMD_WRITE;
        dec_cmd.data = rx_byte_i;
      end
      MODE_READ1: begin
        // A single-byte read behaves as a counted read of one byte.
        dec_cmd.kind = CMD_TAKE;
        dec_cmd.len  = CNT_W'(1);
      end
      MODE_DELIM: begin
        dec_cmd.kind = CMD_SCAN;
        dec_cmd.data = delimiter_i;
        dec_cmd.len  = len_clamped;
      end
      MODE_COUNT: begin
        dec_cmd.kind = CMD_TAKE;
        dec_cmd.len  = len_clamped;
      end
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_ready_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rrbr_back.sv =====
// Back end: owns the buffer pointers and byte store, runs reads and scans.
// Depends on rrbr_pkg and rrbr_ram; holds the result output register.
`default_nettype none

module rrbr_back
  import rrbr_pkg::*;
#(
  parameter int BUF_DEPTH = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  wire cmd_t cmd_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  localparam int PTR_W = $clog2(BUF_DEPTH);
  localparam logic [PTR_W-1:0] LastAddr = PTR_W'(BUF_DEPTH - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_START    = 3'd1;
  localparam logic [2:0] S_TAKE     = 3'd2;
  localparam logic [2:0] S_TAKE_OUT = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_SCAN_CMP = 3'd5;
  localparam logic [2:0] S_RESULT   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [PTR_W-1:0]  wp_q, wp_d, rc_q, rc_d, cur_q, cur_d;
  logic [1:0]        wraps_q, wraps_d, sw_q, sw_d;
  logic [CNT_W-1:0]  n_q, n_d, len_q, len_d;
  logic [BYTE_W-1:0] key_q, key_d;
  logic [1:0]        status_q, status_d;
  cmd_kind_e         kind_q, kind_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic              out_free, overrun;
  logic [PTR_W-1:0]  wp_next, rc_next, cur_next;
  logic [1:0]        rc_wraps_next, cur_wraps_next;

  function automatic logic has_data(input logic [PTR_W-1:0] c, input logic [1:0] w,
                                    input logic [PTR_W-1:0] wp);
    return ((w == 2'd0) && (c < wp)) || (w == 2'd1);
  endfunction

  rrbr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(wp_q),
    .wr_data_i(cmd_i.data),
    .rd_en_i  (ram_re),
    .rd_addr_i(ram_raddr),
    .rd_data_o(ram_rdata)
  );

  assign out_free = !out_valid_q || res_ready_i;
  assign overrun  = (wraps_q == WRAP_SAT) || ((wraps_q == 2'd1) && (wp_q >= rc_q));

  // Wrapping the read side back to zero clears the wrap count.
  assign wp_next        = (wp_q == LastAddr) ? '0 : wp_q + 1'b1;
  assign rc_next        = (rc_q == LastAddr) ? '0 : rc_q + 1'b1;
  assign rc_wraps_next  = (rc_q == LastAddr) ? 2'd0 : wraps_q;
  assign cur_next       = (cur_q == LastAddr) ? '0 : cur_q + 1'b1;
  assign cur_wraps_next = (cur_q == LastAddr) ? 2'd0 : sw_q;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rc_d        = rc_q;
    cur_d       = cur_q;
    wraps_d     = wraps_q;
    sw_d        = sw_q;
    n_d         = n_q;
    len_d       = len_q;
    key_d       = key_q;
    status_d    = status_q;
    kind_d      = kind_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = (state_q == S_SCAN) ? cur_q : rc_q;
    cmd_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          kind_d = cmd_i.kind;
          key_d  = cmd_i.data;
          len_d  = cmd_i.len;
          n_d    = '0;
          unique case (cmd_i.kind) inside
            CMD_WRITE: begin
              ram_we = 1'b1;
              wp_d   = wp_next;
              if ((wp_q == LastAddr) && (wraps_q != WRAP_SAT)) begin
                wraps_d = wraps_q + 2'd1;
              end
            end
            CMD_TAKE, CMD_SCAN: begin
              state_d = S_START;
            end
            default: begin
            end
          endcase
        end
      end
      S_START: begin
        if (overrun) begin
          status_d = STATUS_OVERRUN;
          state_d  = S_RESULT;
        end else if (kind_q == CMD_SCAN) begin
          cur_d   = rc_q;
          sw_d    = wraps_q;
          state_d = S_SCAN;
        end else begin
          state_d = S_TAKE;
        end
      end
      S_TAKE: begin
        if ((n_q == len_q) || !has_data(rc_q, wraps_q, wp_q)) begin
          // Only reachable before the first byte: nothing was taken.
          status_d = (len_q == '0) ? STATUS_OK : STATUS_EMPTY;
          state_d  = S_RESULT;
        end else begin
          ram_re  = 1'b1;
          rc_d    = rc_next;
          wraps_d = rc_wraps_next;
          n_d     = n_q + CNT_W'(1);
          last_d  = ((n_q + CNT_W'(1)) == len_q) ||
                    !has_data(rc_next, rc_wraps_next, wp_q);
          state_d = S_TAKE_OUT;
        end
      end
      S_TAKE_OUT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.read_byte  = ram_rdata;
          out_d.byte_valid = 1'b1;
          out_d.byte_count = n_q;
          out_d.status     = STATUS_OK;
          out_d.last       = last_q;
          state_d          = last_q ? S_IDLE : S_TAKE;
        end
      end
      S_SCAN: begin
        if (n_q == len_q) begin
          status_d = STATUS_EXHAUSTED;
          state_d  = S_RESULT;
        end else if (!has_data(cur_q, sw_q, wp_q)) begin
          status_d = STATUS_EMPTY;
          state_d  = S_RESULT;
        end else begin
          ram_re  = 1'b1;
          cur_d   = cur_next;
          sw_d    = cur_wraps_next;
          n_d     = n_q + CNT_W'(1);
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (ram_rdata == key_q) begin
          // Delimiter found: replay the scanned bytes as a counted read,
          // which commits the cursor as it goes.
          len_d   = n_q;
          n_d     = '0;
          state_d = S_TAKE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.read_byte  = '0;
          out_d.byte_valid = 1'b0;
          out_d.byte_count = '0;
          out_d.status     = status_q;
          out_d.last       = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rc_q        <= '0;
      wraps_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rc_q        <= rc_d;
      wraps_q     <= wraps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    sw_q     <= sw_d;
    n_q      <= n_d;
    len_q    <= len_d;
    key_q    <= key_d;
    status_q <= status_d;
    kind_q   <= kind_d;
    last_q   <= last_d;
    out_q    <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ===== sv/rx_ring_buffer_reader_core.sv =====
// Receive ring buffer reader. Received bytes may queue back to back in the
// two-entry command queue. A single or counted read first checks for overrun
// in S_START, then reads each byte in S_TAKE and returns it in S_TAKE_OUT; a
// delimiter read first reads and compares each scanned byte in S_SCAN and
// S_SCAN_CMP, paced by the one read port of the store and its registered read.
// Reset clears pointers, wrap count and queue; the store contents stay undefined.
`default_nettype none

module rx_ring_buffer_reader_core
  import rrbr_pkg::*;
#(
  parameter int BUF_DEPTH = 256,
  parameter int MAX_READ  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // rx_byte[7:0], delimiter[15:8], max_length[22:16]
  input  wire logic [1:0]  s_axis_tuser_i,  // mode[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // read_byte[7:0], byte_count[14:8]
  output logic [2:0]       m_axis_tuser_o,  // byte_valid[0], status[2:1]
  output logic             m_axis_tlast_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  rrbr_front #(
    .MAX_READ(MAX_READ)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .mode_i      (s_axis_tuser_i),
    .rx_byte_i   (s_axis_tdata_i[7:0]),
    .delimiter_i (s_axis_tdata_i[15:8]),
    .max_length_i(s_axis_tdata_i[22:16]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  rrbr_back #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i),
    .res_o      (res)
  );

  assign m_axis_tdata_o = {1'b0, res.byte_count, res.read_byte};
  assign m_axis_tuser_o = {res.status, res.byte_valid};
  assign m_axis_tlast_o = res.last;

endmodule

`default_nettype wire
